FILE: design/dtlm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtlm_pkg;

   localparam int RawWidth      = 21;
   localparam int GcrWidth      = 20;
   localparam int PeriodWidth   = 16;
   localparam int RpmWidth      = 16;
   localparam int PolesWidth    = 8;
   localparam int PairsWidth    = PolesWidth - 1;
   localparam int DivisorWidth  = PeriodWidth + PairsWidth;
   localparam int DividendWidth = 26;
   localparam int DivStages     = RpmWidth;

   localparam logic [PolesWidth-1:0]    PolesReset  = 8'd14;
   localparam logic [DividendWidth-1:0] DivDividend = 26'd60000000;
   // below this divisor the quotient no longer fits in 16 bits
   localparam logic [DivisorWidth-1:0]  SatLimit    =
      DivisorWidth'(DivDividend >> RpmWidth) + DivisorWidth'(1);

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_GCR  = 2'd1,
      ERR_CRC  = 2'd2
   } err_code_type;

   typedef struct packed {
      logic                   ok;
      err_code_type           err;
      logic [PeriodWidth-1:0] period;
   } dtlm_meta_type;

   // {bad, nibble}
   function automatic logic [4:0] gcr_decode(input logic [4:0] code);
      logic [4:0] res;
      case (code)
         5'd9:    res = {1'b0, 4'h9};
         5'd10:   res = {1'b0, 4'hA};
         5'd11:   res = {1'b0, 4'hB};
         5'd13:   res = {1'b0, 4'hD};
         5'd14:   res = {1'b0, 4'hE};
         5'd15:   res = {1'b0, 4'hF};
         5'd18:   res = {1'b0, 4'h2};
         5'd19:   res = {1'b0, 4'h3};
         5'd21:   res = {1'b0, 4'h5};
         5'd22:   res = {1'b0, 4'h6};
         5'd23:   res = {1'b0, 4'h7};
         5'd25:   res = {1'b0, 4'h0};
         5'd26:   res = {1'b0, 4'h8};
         5'd27:   res = {1'b0, 4'h1};
         5'd29:   res = {1'b0, 4'h4};
         5'd30:   res = {1'b0, 4'hC};
         default: res = {1'b1, 4'h0};
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: design/dtlm_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dtlm_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [dtlm_pkg::DivisorWidth-1:0]  in_divisor,
   input  dtlm_pkg::dtlm_meta_type            in_meta,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [dtlm_pkg::RpmWidth-1:0]      out_rpm,
   output dtlm_pkg::dtlm_meta_type            out_meta
);
   import dtlm_pkg::*;

   localparam int RemInitWidth = DividendWidth - DivStages;

   logic [DivStages:0]      valid_ff;
   logic [DivStages:0]      en;
   logic [DivisorWidth-1:0] divisor_ff [0:DivStages-1];
   logic [DivisorWidth-1:0] rem_ff     [0:DivStages-1];
   logic [RpmWidth-1:0]     quot_ff    [0:DivStages];
   logic                    sat_ff     [0:DivStages];
   logic                    zero_ff    [0:DivStages];
   dtlm_meta_type           meta_ff    [0:DivStages];

   // a stage moves when it is empty or its successor moves
   assign en[DivStages] = !valid_ff[DivStages] || out_ready;
   assign en[0]         = !valid_ff[0] || en[1];
   assign in_ready      = en[0];

   // setup stage: remainder starts with the dividend bits above the quotient
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en[0]) begin
         valid_ff[0] <= in_valid;
      end
      if (en[0] && in_valid) begin
         divisor_ff[0] <= in_divisor;
         rem_ff[0]     <= {{(DivisorWidth-RemInitWidth){1'b0}},
                           DivDividend[DividendWidth-1:DivStages]};
         quot_ff[0]    <= '0;
         sat_ff[0]     <= (in_divisor < SatLimit);
         zero_ff[0]    <= (in_divisor == '0);
         meta_ff[0]    <= in_meta;
      end
   end

   for (genvar i = 1; i <= DivStages; i++) begin : g_step
      logic [DivisorWidth:0]   trial;
      logic                    ge;
      logic [RpmWidth-1:0]     quot_in;

      if (i < DivStages) begin : g_en
         assign en[i] = !valid_ff[i] || en[i+1];
      end

      assign trial   = {rem_ff[i-1], DivDividend[DivStages-i]};
      assign ge      = (trial >= {1'b0, divisor_ff[i-1]});
      assign quot_in = {quot_ff[i-1][RpmWidth-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en[i]) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         if (en[i] && valid_ff[i-1]) begin
            quot_ff[i] <= quot_in;
            sat_ff[i]  <= sat_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
            meta_ff[i] <= meta_ff[i-1];
         end
      end

      if (i < DivStages) begin : g_rem
         logic [DivisorWidth:0]   diff;
         logic [DivisorWidth-1:0] rem_in;
         assign diff   = trial - {1'b0, divisor_ff[i-1]};
         assign rem_in = ge ? diff[DivisorWidth-1:0] : trial[DivisorWidth-1:0];
         always_ff @(posedge clock) begin
            if (en[i] && valid_ff[i-1]) begin
               rem_ff[i]     <= rem_in;
               divisor_ff[i] <= divisor_ff[i-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[DivStages];
   assign out_meta  = meta_ff[DivStages];
   assign out_rpm   = zero_ff[DivStages] ? '0 :
                      sat_ff[DivStages]  ? '1 : quot_ff[DivStages];

endmodule

`default_nettype wire

FILE: design/dshot_erpm_telemetry_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | ports                                    | dir
// ---------+------------------------------------------+-----
// request  | req_valid, req_ready, req_raw_bits       | in
// response | rsp_valid, rsp_ready, rsp_valid_res,     | out
//          | rsp_error_code, rsp_period_us, rsp_rpm   |
// csr      | csr_wr_en, csr_wr_data (motor_poles)     | in
//
// One beat per cycle in, one per cycle out, while rsp_ready stays high.
// Stages: GCR/CRC decode, period x pole pairs, divider setup, then
// 16 restoring-division stages, one quotient bit each (last is the output).
// Each stage holds only when full and its successor holds, so bubbles fill.
// Synchronous reset empties the pipe and sets motor_poles to 14.

module dshot_erpm_telemetry_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dtlm_pkg::RawWidth-1:0]     req_raw_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_valid_res,
   output logic [1:0]                        rsp_error_code,
   output logic [dtlm_pkg::PeriodWidth-1:0]  rsp_period_us,
   output logic [dtlm_pkg::RpmWidth-1:0]     rsp_rpm,
   input  logic                              csr_wr_en,
   input  logic [dtlm_pkg::PolesWidth-1:0]   csr_wr_data
);
   import dtlm_pkg::*;

   logic [PolesWidth-1:0]   poles_ff;
   logic [PairsWidth-1:0]   pairs;

   logic [GcrWidth-1:0]     gcr;
   logic [4:0]              dec3, dec2, dec1, dec0;
   logic                    gcr_bad;
   logic [15:0]             word;
   logic [11:0]             val;
   logic                    crc_ok;
   logic [PeriodWidth-1:0]  period;
   dtlm_meta_type           a_meta_in;

   logic                    a_en, b_en;
   logic                    a_valid_ff, b_valid_ff;
   dtlm_meta_type           a_meta_ff, b_meta_ff;
   logic [DivisorWidth-1:0] b_divisor_in, b_divisor_ff;

   logic                    div_ready;
   dtlm_meta_type           out_meta;

   always_ff @(posedge clock) begin
      if (reset) begin
         poles_ff <= PolesReset;
      end else if (csr_wr_en) begin
         poles_ff <= csr_wr_data;
      end
   end

   assign pairs = (poles_ff < PolesWidth'(2)) ? PairsWidth'(1) : poles_ff[PolesWidth-1:1];

   // NRZI: each bit is a transition flag against its predecessor
   assign gcr  = req_raw_bits[GcrWidth-1:0] ^ req_raw_bits[RawWidth-1:1];
   assign dec3 = gcr_decode(gcr[19:15]);
   assign dec2 = gcr_decode(gcr[14:10]);
   assign dec1 = gcr_decode(gcr[9:5]);
   assign dec0 = gcr_decode(gcr[4:0]);
   assign gcr_bad = dec3[4] | dec2[4] | dec1[4] | dec0[4];
   assign word    = {dec3[3:0], dec2[3:0], dec1[3:0], dec0[3:0]};
   assign val     = word[15:4];
   assign crc_ok  = ((val[11:8] ^ val[7:4] ^ val[3:0]) == word[3:0]);
   assign period  = {{(PeriodWidth-9){1'b0}}, val[8:0]} << val[11:9];

   always_comb begin
      a_meta_in.ok     = 1'b0;
      a_meta_in.err    = ERR_NONE;
      a_meta_in.period = '0;
      if (gcr_bad) begin
         a_meta_in.err = ERR_GCR;
      end else if (!crc_ok) begin
         a_meta_in.err = ERR_CRC;
      end else begin
         a_meta_in.ok     = 1'b1;
         a_meta_in.period = period;
      end
   end

   assign a_en      = !a_valid_ff || b_en;
   assign b_en      = !b_valid_ff || div_ready;
   assign req_ready = a_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= req_valid;
      end
      if (a_en && req_valid) begin
         a_meta_ff <= a_meta_in;
      end
   end

   // error beats carry period 0, so the divisor is 0 and rpm comes out 0
   assign b_divisor_in = DivisorWidth'(a_meta_ff.period * pairs);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_en && a_valid_ff) begin
         b_meta_ff    <= a_meta_ff;
         b_divisor_ff <= b_divisor_in;
      end
   end

   dtlm_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (b_valid_ff),
      .in_ready   (div_ready),
      .in_divisor (b_divisor_ff),
      .in_meta    (b_meta_ff),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_rpm    (rsp_rpm),
      .out_meta   (out_meta)
   );

   assign rsp_valid_res  = out_meta.ok;
   assign rsp_error_code = out_meta.err;
   assign rsp_period_us  = out_meta.period;

endmodule

`default_nettype wire

FILE: tb/sv/dshot_erpm_telemetry_decoder_core_test.sv
`timescale 1ns / 1ps

module dshot_erpm_telemetry_decoder_core_test;
   import dtlm_pkg::*;

   localparam int StallLimit = 5000;
   localparam int LongHold   = 400;
   localparam int PhaseItems = 220;

   // nibble per 5-bit line code, code 31 in the top digit; unmapped codes read 0
   localparam logic [127:0] NibbleTable = 128'h0C401800_76503200_FED0BA90_00000000;
   localparam logic [31:0]  GcrValidMask = 32'h6EECEE00;

   typedef struct packed {
      logic                   ok;
      err_code_type           err;
      logic [PeriodWidth-1:0] period;
      logic [RpmWidth-1:0]    rpm;
   } telem_result_type;

   logic                   clock;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   logic [RawWidth-1:0]    req_raw_bits = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   logic                   rsp_valid_res;
   logic [1:0]             rsp_error_code;
   logic [PeriodWidth-1:0] rsp_period_us;
   logic [RpmWidth-1:0]    rsp_rpm;
   logic                   csr_wr_en    = 1'b0;
   logic [PolesWidth-1:0]  csr_wr_data  = '0;

   logic [RawWidth-1:0]   pending_raw[$];
   telem_result_type      expected_results[$];
   logic [PolesWidth-1:0] poles_setting = PolesReset;
   int                    idle_pct      = 0;
   bit                    long_hold_req = 1'b0;
   int                    send_gap      = 0;
   int                    hold_left     = 0;
   int                    stall_cycles  = 0;
   int                    mismatches    = 0;
   int                    results_seen  = 0;

   dshot_erpm_telemetry_decoder_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_raw_bits   (req_raw_bits),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_error_code (rsp_error_code),
      .rsp_period_us  (rsp_period_us),
      .rsp_rpm        (rsp_rpm),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic telem_result_type decode_telemetry(logic [RawWidth-1:0] raw,
                                                         logic [PolesWidth-1:0] poles);
      logic [GcrWidth-1:0] gcr;
      logic [15:0]         word;
      logic [4:0]          code;
      logic [11:0]         val;
      int unsigned         period;
      int unsigned         pairs;
      int unsigned         rate;
      int                  g;
      telem_result_type    r;
      r.ok     = 1'b0;
      r.err    = ERR_NONE;
      r.period = '0;
      r.rpm    = '0;
      gcr  = raw[GcrWidth-1:0] ^ raw[RawWidth-1:1];
      word = '0;
      for (g = 3; g >= 0; g--) begin
         code = gcr[g*5 +: 5];
         if (!GcrValidMask[code]) begin
            r.err = ERR_GCR;
            return r;
         end
         word = {word[11:0], NibbleTable[code*4 +: 4]};
      end
      val = word[15:4];
      if ((val[3:0] ^ val[7:4] ^ val[11:8]) != word[3:0]) begin
         r.err = ERR_CRC;
         return r;
      end
      period = 32'(val[8:0]) << val[11:9];
      rate   = 0;
      if (period != 0) begin
         pairs = (poles < 2) ? 1 : 32'(poles) / 2;
         rate  = 60000000 / period / pairs;
         if (rate > 65535) rate = 65535;
      end
      r.ok     = 1'b1;
      r.period = period[15:0];
      r.rpm    = rate[15:0];
      return r;
   endfunction

   function automatic logic [4:0] gcr_code_of(logic [3:0] nib);
      case (nib)
         4'h0:    return 5'd25;
         4'h1:    return 5'd27;
         4'h2:    return 5'd18;
         4'h3:    return 5'd19;
         4'h4:    return 5'd29;
         4'h5:    return 5'd21;
         4'h6:    return 5'd22;
         4'h7:    return 5'd23;
         4'h8:    return 5'd26;
         4'hC:    return 5'd30;
         default: return {1'b0, nib};  // 9..B, D..F map to themselves
      endcase
   endfunction

   function automatic logic [4:0] any_bad_code();
      logic [4:0] c;
      c = 5'($urandom_range(31, 0));
      while (GcrValidMask[c]) c = 5'($urandom_range(31, 0));
      return c;
   endfunction

   // line word for a 12-bit value; crc_flip corrupts the checksum, bad_group >= 0
   // swaps that group for an unmapped code; top picks the free NRZI start level
   function automatic logic [RawWidth-1:0] build_raw(logic [11:0] val, logic [3:0] crc_flip,
                                                     int bad_group, logic [4:0] bad_code,
                                                     logic top);
      logic [15:0]         word;
      logic [GcrWidth-1:0] gcr;
      logic [RawWidth-1:0] raw;
      int                  i;
      word = {val, val[3:0] ^ val[7:4] ^ val[11:8] ^ crc_flip};
      for (i = 0; i < 4; i++) gcr[i*5 +: 5] = gcr_code_of(word[i*4 +: 4]);
      if (bad_group >= 0) gcr[bad_group*5 +: 5] = bad_code;
      raw[RawWidth-1] = top;
      for (i = GcrWidth - 1; i >= 0; i--) raw[i] = gcr[i] ^ raw[i+1];
      return raw;
   endfunction

   function automatic logic [RawWidth-1:0] random_raw();
      logic [2:0]  ex;
      logic [8:0]  mant;
      int          pick;
      logic        top;
      ex   = 3'($urandom_range(7, 0));
      mant = ($urandom_range(3, 0) == 0) ? 9'($urandom_range(7, 0)) : 9'($urandom_range(511, 0));
      top  = 1'($urandom_range(1, 0));
      pick = $urandom_range(99, 0);
      if (pick < 70) return build_raw({ex, mant}, 4'h0, -1, 5'd0, top);
      if (pick < 80) return build_raw({ex, mant}, 4'($urandom_range(15, 1)), -1, 5'd0, top);
      if (pick < 90)
         return build_raw({ex, mant}, 4'h0, $urandom_range(3, 0), any_bad_code(), top);
      return RawWidth'($urandom_range(2**RawWidth - 1, 0));
   endfunction

   task automatic note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(decode_telemetry(req_raw_bits, poles_setting));
         if (!req_valid || req_ready) begin
            if (send_gap == 0 && idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
               send_gap = $urandom_range(8, 1);
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_raw.size() != 0) begin
               req_valid    <= 1'b1;
               req_raw_bits <= pending_raw.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      telem_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               note_mismatch($sformatf("beat %0d arrived with nothing expected", results_seen));
            end else begin
               want = expected_results.pop_front();
               if (rsp_valid_res !== want.ok || rsp_error_code !== want.err ||
                   rsp_period_us !== want.period || rsp_rpm !== want.rpm)
                  note_mismatch($sformatf(
                     "beat %0d: expected ok=%0b err=%0d period=%0d rpm=%0d, got %b %0d %0d %0d",
                     results_seen, want.ok, want.err, want.period, want.rpm,
                     rsp_valid_res, rsp_error_code, rsp_period_us, rsp_rpm));
            end
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LongHold;
         end else if (hold_left == 0 && idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            hold_left = $urandom_range(8, 1);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      @(negedge clock);
      while (pending_raw.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic run_phase(logic [PolesWidth-1:0] poles, int idle, bit hold);
      int n;
      wait_drained();
      @(posedge clock);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= poles;
      poles_setting = poles;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      idle_pct      = idle;
      long_hold_req = hold;
      for (n = 0; n < PhaseItems; n++) pending_raw.push_back(random_raw());
   endtask

   initial begin
      int g;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed pass at the reset pole count
      @(negedge clock);
      idle_pct = 20;
      pending_raw.push_back(build_raw({3'd0, 9'd0}, 4'h0, -1, 5'd0, 1'b0));   // zero period
      pending_raw.push_back(build_raw({3'd7, 9'd0}, 4'h0, -1, 5'd0, 1'b1));
      pending_raw.push_back(build_raw({3'd7, 9'd511}, 4'h0, -1, 5'd0, 1'b0)); // longest period
      pending_raw.push_back(build_raw({3'd0, 9'd1}, 4'h0, -1, 5'd0, 1'b1));   // saturates
      pending_raw.push_back(build_raw({3'd0, 9'd511}, 4'h0, -1, 5'd0, 1'b0));
      pending_raw.push_back(build_raw({3'd3, 9'd300}, 4'h0, -1, 5'd0, 1'b1));
      pending_raw.push_back(build_raw({3'd2, 9'd77}, 4'h1, -1, 5'd0, 1'b0));  // crc error
      pending_raw.push_back(build_raw({3'd5, 9'd400}, 4'hF, -1, 5'd0, 1'b1));
      for (g = 0; g < 4; g++)
         pending_raw.push_back(build_raw({3'd4, 9'd123}, 4'h0, g, any_bad_code(), g[0]));
      // bad group ahead of a bad checksum: group error wins
      pending_raw.push_back(build_raw({3'd1, 9'd9}, 4'h6, 1, 5'd31, 1'b0));
      pending_raw.push_back('0);
      pending_raw.push_back({RawWidth{1'b1}});
      pending_raw.push_back(21'h155555);
      pending_raw.push_back(21'h0AAAAA);

      run_phase(8'd0, 25, 1'b0);
      run_phase(8'd1, 0, 1'b0);
      run_phase(8'd2, 40, 1'b1);   // receiver holds off long enough to back up the pipe
      run_phase(8'd255, 10, 1'b0);
      run_phase(8'd254, 60, 1'b0);
      run_phase(8'd3, 25, 1'b0);
      run_phase(8'($urandom_range(255, 4)), 15, 1'b0);
      run_phase(PolesReset, 0, 1'b0);

      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
